// ===== hdl/flash_stage_timing_scoreboard_macros.svh =====
// Assertion macros for the flash stage timing scoreboard checker
`ifndef FLASH_STAGE_TIMING_SCOREBOARD_MACROS_SVH
`define FLASH_STAGE_TIMING_SCOREBOARD_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define FSTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FSTS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fsts_pkg.sv =====
// Shared types, codes and helpers of the flash stage timing scoreboard
package fsts_pkg;

    localparam int DUR_W      = 24;
    localparam int OUT_TIME_W = 48;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CMD_ADDR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VEC_XFER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLC_XFER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ARR_READ = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPUTE  = 3'd4;

    localparam logic [DUR_W-1:0] RST_CMD_ADDR = 24'd7;
    localparam logic [DUR_W-1:0] RST_VEC_XFER = 24'd64;
    localparam logic [DUR_W-1:0] RST_SLC_XFER = 24'd256;
    localparam logic [DUR_W-1:0] RST_ARR_READ = 24'd3000;
    localparam logic [DUR_W-1:0] RST_COMPUTE  = 24'd64;

    localparam logic REQ_COMPUTE = 1'b0;
    localparam logic REQ_SLICE   = 1'b1;

    localparam logic [2:0] STAGE_CMD     = 3'd0;
    localparam logic [2:0] STAGE_VEC     = 3'd1;
    localparam logic [2:0] STAGE_ARRAY   = 3'd2;
    localparam logic [2:0] STAGE_COMPUTE = 3'd3;
    localparam logic [2:0] STAGE_SLICE   = 3'd4;

    typedef struct packed {
        logic       req_type;
        logic [2:0] channel_idx;
        logic [2:0] chip_idx;
        logic [1:0] die_idx;
        logic [1:0] plane_idx;
    } t_cmd;

    typedef struct packed {
        logic [2:0]            stage_code;
        logic [OUT_TIME_W-1:0] stage_start;
        logic [OUT_TIME_W-1:0] stage_end;
        logic [OUT_TIME_W-1:0] latest_end;
        logic                  last_stage;
    } t_res;

    // small index reduced modulo a count
    function automatic logic [2:0] wrap_idx(input logic [2:0] v, input int unsigned n);
        logic [2:0] r;
        r = v;
        for (int i = 0; i < 7; i++) begin
            if ({29'd0, r} >= n) begin
                r = r - 3'(n);
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/flash_stage_timing_scoreboard.sv =====
// Flash stage timing scoreboard top level.
// Commands enter through a queue (push/full) and stage results leave through a queue
// (pop/empty); a read-compute yields four stage results and a read-slice two, the last
// one flagged. The back sequencer takes one command at a time: it picks the command up,
// reads the channel, chip, die and plane ready tables, loads them, runs each stage in
// turn and writes the tables back; a stage moves on only once the result before it has
// gone into the result queue. After reset the tables are swept to zero at one entry per
// cycle, over NUM_CHANNELS*CH_CHIPS*CHIP_DIES*DIE_PLANES plane entries (1024 by default),
// during which full stays high. Configuration writes belong between commands, with no
// transaction in flight.
module flash_stage_timing_scoreboard #(
    parameter int NUM_CHANNELS = 8,
    parameter int CH_CHIPS     = 8,
    parameter int CHIP_DIES    = 4,
    parameter int DIE_PLANES   = 4,
    parameter int TIME_WIDTH   = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  fsts_pkg::t_cmd                 i_cmd,
    output logic                           empty,
    input  logic                           pop,
    output fsts_pkg::t_res                 o_res,
    input  logic                           i_cfg_we,
    input  logic [fsts_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fsts_pkg::DUR_W-1:0]     i_cfg_data
);
    localparam int N_CHIP  = NUM_CHANNELS * CH_CHIPS;
    localparam int N_DIE   = N_CHIP * CHIP_DIES;
    localparam int N_PLANE = N_DIE * DIE_PLANES;
    localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CHIP_W  = (N_CHIP > 1) ? $clog2(N_CHIP) : 1;
    localparam int DIE_W   = (N_DIE > 1) ? $clog2(N_DIE) : 1;
    localparam int PL_W    = (N_PLANE > 1) ? $clog2(N_PLANE) : 1;
    localparam int DEC_W   = 1 + CH_W + CHIP_W + DIE_W + PL_W;
    localparam int RES_W   = $bits(fsts_pkg::t_res);

    logic             q_push, q_full, q_empty, q_pop, busy;
    logic [DEC_W-1:0] q_in, q_out;
    logic             res_push, res_full;
    fsts_pkg::t_res   res_in;
    logic [RES_W-1:0] res_out;

    fsts_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .CH_CHIPS     (CH_CHIPS),
        .CHIP_DIES    (CHIP_DIES),
        .DIE_PLANES   (DIE_PLANES)
    ) u_front (
        .i_push   (push),
        .i_cmd    (i_cmd),
        .i_q_full (q_full),
        .i_busy   (busy),
        .o_full   (full),
        .o_q_push (q_push),
        .o_q_data (q_in)
    );

    fsts_fifo #(
        .DATA_W (DEC_W),
        .DEPTH  (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    fsts_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .CH_CHIPS     (CH_CHIPS),
        .CHIP_DIES    (CHIP_DIES),
        .DIE_PLANES   (DIE_PLANES),
        .TIME_WIDTH   (TIME_WIDTH),
        .DEC_W        (DEC_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_empty  (q_empty),
        .i_q_data   (q_out),
        .o_q_pop    (q_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res_in),
        .o_busy     (busy)
    );

    fsts_fifo #(
        .DATA_W (RES_W),
        .DEPTH  (4)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_res = res_out;

endmodule

// ===== hdl/fsts_fifo.sv =====
// Small register queue used between the scoreboard stages and at the result side
module fsts_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_buf [DEPTH];
    logic [AW-1:0]     r_wp, r_rp;
    logic [CW-1:0]     r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/fsts_front.sv =====
// Command intake: accepts a transaction and resolves its flat table indices
module fsts_front #(
    parameter int NUM_CHANNELS = 8,
    parameter int CH_CHIPS     = 8,
    parameter int CHIP_DIES    = 4,
    parameter int DIE_PLANES   = 4
) (
    input  logic          i_push,
    input  fsts_pkg::t_cmd i_cmd,
    input  logic          i_q_full,
    input  logic          i_busy,
    output logic          o_full,
    output logic          o_q_push,
    output logic [(((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)
                  + ((NUM_CHANNELS * CH_CHIPS > 1)
                     ? $clog2(NUM_CHANNELS * CH_CHIPS) : 1)
                  + ((NUM_CHANNELS * CH_CHIPS * CHIP_DIES > 1)
                     ? $clog2(NUM_CHANNELS * CH_CHIPS * CHIP_DIES) : 1)
                  + ((NUM_CHANNELS * CH_CHIPS * CHIP_DIES * DIE_PLANES > 1)
                     ? $clog2(NUM_CHANNELS * CH_CHIPS * CHIP_DIES
                              * DIE_PLANES) : 1)
                  + 1) - 1:0] o_q_data
);
    localparam int N_CHIP  = NUM_CHANNELS * CH_CHIPS;
    localparam int N_DIE   = N_CHIP * CHIP_DIES;
    localparam int N_PLANE = N_DIE * DIE_PLANES;
    localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CHIP_W  = (N_CHIP > 1) ? $clog2(N_CHIP) : 1;
    localparam int DIE_W   = (N_DIE > 1) ? $clog2(N_DIE) : 1;
    localparam int PL_W    = (N_PLANE > 1) ? $clog2(N_PLANE) : 1;

    logic [2:0]        ch3, cp3, di3, pl3;
    logic [CH_W-1:0]   ch;
    logic [CHIP_W-1:0] chip_i;
    logic [DIE_W-1:0]  die_i;
    logic [PL_W-1:0]   plane_i;

    assign ch3 = fsts_pkg::wrap_idx(i_cmd.channel_idx, NUM_CHANNELS);
    assign cp3 = fsts_pkg::wrap_idx(i_cmd.chip_idx, CH_CHIPS);
    assign di3 = fsts_pkg::wrap_idx({1'b0, i_cmd.die_idx}, CHIP_DIES);
    assign pl3 = fsts_pkg::wrap_idx({1'b0, i_cmd.plane_idx}, DIE_PLANES);

    assign ch      = CH_W'(ch3);
    assign chip_i  = CHIP_W'(int'(ch3) * CH_CHIPS + int'(cp3));
    assign die_i   = DIE_W'(int'(chip_i) * CHIP_DIES + int'(di3));
    assign plane_i = PL_W'(int'(die_i) * DIE_PLANES + int'(pl3));

    assign o_full   = i_q_full || i_busy;
    assign o_q_push = i_push && !o_full;
    assign o_q_data = {i_cmd.req_type, ch, chip_i, die_i, plane_i};

endmodule

// ===== hdl/fsts_back.sv =====
// Stage sequencer: ready-time tables, per-stage scheduling and result emission
module fsts_back #(
    parameter int NUM_CHANNELS = 8,
    parameter int CH_CHIPS     = 8,
    parameter int CHIP_DIES    = 4,
    parameter int DIE_PLANES   = 4,
    parameter int TIME_WIDTH   = 48,
    parameter int DEC_W        = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fsts_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fsts_pkg::DUR_W-1:0]         i_cfg_data,
    input  logic                               i_q_empty,
    input  logic [DEC_W-1:0]                   i_q_data,
    output logic                               o_q_pop,
    input  logic                               i_res_full,
    output logic                               o_res_push,
    output fsts_pkg::t_res                     o_res,
    output logic                               o_busy
);
    localparam int N_CHIP  = NUM_CHANNELS * CH_CHIPS;
    localparam int N_DIE   = N_CHIP * CHIP_DIES;
    localparam int N_PLANE = N_DIE * DIE_PLANES;
    localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CHIP_W  = (N_CHIP > 1) ? $clog2(N_CHIP) : 1;
    localparam int DIE_W   = (N_DIE > 1) ? $clog2(N_DIE) : 1;
    localparam int PL_W    = (N_PLANE > 1) ? $clog2(N_PLANE) : 1;
    localparam int O_DIE   = PL_W;
    localparam int O_CHIP  = O_DIE + DIE_W;
    localparam int O_CH    = O_CHIP + CHIP_W;
    localparam int O_SLC   = O_CH + CH_W;
    localparam int TW      = TIME_WIDTH;
    localparam int DW      = fsts_pkg::DUR_W;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_LD   = 3'd3;
    localparam logic [2:0] ST_STG  = 3'd4;
    localparam logic [2:0] ST_WB   = 3'd5;

    logic [DW-1:0] r_dur_cmd, r_dur_vec, r_dur_slc, r_dur_arr, r_dur_cmp;

    logic [2:0]       r_state, n_state;
    logic [PL_W-1:0]  r_clr;
    logic [DEC_W-1:0] r_cmd;
    logic [1:0]       r_stg;

    logic [TW-1:0] m_ch    [NUM_CHANNELS];
    logic [TW-1:0] m_chip  [N_CHIP];
    logic [TW-1:0] m_die   [N_DIE];
    logic [TW-1:0] m_plane [N_PLANE];
    logic [TW-1:0] r_ch_rd, r_chip_rd, r_cu_rd, r_plane_rd;
    logic [TW-1:0] r_ch_t, r_chip_t, r_cu_t, r_plane_t;

    logic          r_pend;
    logic [2:0]    r_pend_code;
    logic [TW-1:0] r_pend_s, r_pend_e;
    logic          r_pend_last;
    logic [TW-1:0] r_max, n_max;

    logic              slice;
    logic [CH_W-1:0]   a_ch;
    logic [CHIP_W-1:0] a_chip;
    logic [DIE_W-1:0]  a_die;
    logic [PL_W-1:0]   a_pl;

    logic              clr_mode, wb_mode, clr_chip, clr_die, clr_ch;
    logic [CH_W-1:0]   w_ch;
    logic [CHIP_W-1:0] w_chip;
    logic [DIE_W-1:0]  w_die;
    logic [PL_W-1:0]   w_pl;

    logic [TW-1:0] op_a, op_b, st_s, st_e, st_sum;
    logic [DW-1:0] st_dur;
    logic [2:0]    st_code;
    logic          st_last, st_carry, stg_go;

    assign slice  = r_cmd[O_SLC];
    assign a_ch   = r_cmd[O_SLC-1:O_CH];
    assign a_chip = r_cmd[O_CH-1:O_CHIP];
    assign a_die  = r_cmd[O_CHIP-1:O_DIE];
    assign a_pl   = r_cmd[PL_W-1:0];

    assign o_busy  = (r_state == ST_CLR);
    assign o_q_pop = (r_state == ST_IDLE) && !i_q_empty;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur_cmd <= fsts_pkg::RST_CMD_ADDR;
            r_dur_vec <= fsts_pkg::RST_VEC_XFER;
            r_dur_slc <= fsts_pkg::RST_SLC_XFER;
            r_dur_arr <= fsts_pkg::RST_ARR_READ;
            r_dur_cmp <= fsts_pkg::RST_COMPUTE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fsts_pkg::CFG_CMD_ADDR: r_dur_cmd <= i_cfg_data;
                fsts_pkg::CFG_VEC_XFER: r_dur_vec <= i_cfg_data;
                fsts_pkg::CFG_SLC_XFER: r_dur_slc <= i_cfg_data;
                fsts_pkg::CFG_ARR_READ: r_dur_arr <= i_cfg_data;
                fsts_pkg::CFG_COMPUTE:  r_dur_cmp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // table write ports: clearing sweep or command write-back
    assign clr_mode = (r_state == ST_CLR);
    assign wb_mode  = (r_state == ST_WB);
    assign clr_ch   = {1'b0, r_clr} < (PL_W + 1)'(NUM_CHANNELS);
    assign clr_chip = {1'b0, r_clr} < (PL_W + 1)'(N_CHIP);
    assign clr_die  = {1'b0, r_clr} < (PL_W + 1)'(N_DIE);
    assign w_ch     = clr_mode ? r_clr[CH_W-1:0] : a_ch;
    assign w_chip   = clr_mode ? r_clr[CHIP_W-1:0] : a_chip;
    assign w_die    = clr_mode ? r_clr[DIE_W-1:0] : a_die;
    assign w_pl     = clr_mode ? r_clr : a_pl;

    always_ff @(posedge i_clk) begin
        if ((clr_mode && clr_ch) || wb_mode) begin
            m_ch[w_ch] <= clr_mode ? '0 : r_ch_t;
        end
        if (r_state == ST_RD) begin
            r_ch_rd <= m_ch[a_ch];
        end
    end

    always_ff @(posedge i_clk) begin
        if ((clr_mode && clr_chip) || wb_mode) begin
            m_chip[w_chip] <= clr_mode ? '0 : r_chip_t;
        end
        if (r_state == ST_RD) begin
            r_chip_rd <= m_chip[a_chip];
        end
    end

    always_ff @(posedge i_clk) begin
        if ((clr_mode && clr_die) || wb_mode) begin
            m_die[w_die] <= clr_mode ? '0 : r_cu_t;
        end
        if (r_state == ST_RD) begin
            r_cu_rd <= m_die[a_die];
        end
    end

    always_ff @(posedge i_clk) begin
        if (clr_mode || wb_mode) begin
            m_plane[w_pl] <= clr_mode ? '0 : r_plane_t;
        end
        if (r_state == ST_RD) begin
            r_plane_rd <= m_plane[a_pl];
        end
    end

    // stage operand selection
    always_comb begin
        case (r_stg)
            2'd0: begin
                op_a    = r_ch_t;
                op_b    = r_chip_t;
                st_dur  = r_dur_cmd;
                st_code = fsts_pkg::STAGE_CMD;
                st_last = 1'b0;
            end
            2'd1: begin
                op_a    = r_ch_t;
                op_b    = r_chip_t;
                st_dur  = (slice == fsts_pkg::REQ_SLICE) ? r_dur_slc : r_dur_vec;
                st_code = (slice == fsts_pkg::REQ_SLICE) ? fsts_pkg::STAGE_SLICE
                                                         : fsts_pkg::STAGE_VEC;
                st_last = (slice == fsts_pkg::REQ_SLICE);
            end
            2'd2: begin
                op_a    = r_chip_t;
                op_b    = r_plane_t;
                st_dur  = r_dur_arr;
                st_code = fsts_pkg::STAGE_ARRAY;
                st_last = 1'b0;
            end
            default: begin
                // plane holds the array-read end here
                op_a    = r_plane_t;
                op_b    = r_cu_t;
                st_dur  = r_dur_cmp;
                st_code = fsts_pkg::STAGE_COMPUTE;
                st_last = 1'b1;
            end
        endcase
    end

    assign st_s               = (op_a > op_b) ? op_a : op_b;
    assign {st_carry, st_sum} = {1'b0, st_s} + (TW + 1)'(st_dur);
    assign st_e               = st_carry ? '1 : st_sum;

    assign o_res_push = r_pend && !i_res_full;
    assign stg_go     = (r_state == ST_STG) && (!r_pend || o_res_push);
    assign n_max      = (r_pend_e > r_max) ? r_pend_e : r_max;

    always_comb begin
        o_res.stage_code  = r_pend_code;
        o_res.stage_start = fsts_pkg::OUT_TIME_W'(r_pend_s);
        o_res.stage_end   = fsts_pkg::OUT_TIME_W'(r_pend_e);
        o_res.latest_end  = fsts_pkg::OUT_TIME_W'(n_max);
        o_res.last_stage  = r_pend_last;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLR:  if (r_clr == PL_W'(N_PLANE - 1)) n_state = ST_IDLE;
            ST_IDLE: if (!i_q_empty) n_state = ST_RD;
            ST_RD:   n_state = ST_LD;
            ST_LD:   n_state = ST_STG;
            ST_STG:  if (stg_go && st_last) n_state = ST_WB;
            ST_WB:   n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr   <= '0;
            r_stg   <= '0;
            r_pend  <= 1'b0;
            r_max   <= '0;
        end else begin
            r_state <= n_state;
            if (clr_mode) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == ST_LD) begin
                r_stg <= '0;
            end else if (stg_go) begin
                r_stg <= r_stg + 1'b1;
            end
            if (stg_go) begin
                r_pend <= 1'b1;
            end else if (o_res_push) begin
                r_pend <= 1'b0;
            end
            if (o_res_push) begin
                r_max <= n_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_data;
        end
        if (r_state == ST_LD) begin
            r_ch_t    <= r_ch_rd;
            r_chip_t  <= r_chip_rd;
            r_cu_t    <= r_cu_rd;
            r_plane_t <= r_plane_rd;
        end else if (stg_go) begin
            case (r_stg)
                2'd0, 2'd1: begin
                    r_ch_t   <= st_e;
                    r_chip_t <= st_e;
                end
                2'd2: begin
                    r_chip_t  <= st_e;
                    r_plane_t <= st_e;
                end
                default: begin
                    r_cu_t    <= st_e;
                    r_chip_t  <= st_e;
                    r_plane_t <= st_e;
                end
            endcase
        end
        if (stg_go) begin
            r_pend_code <= st_code;
            r_pend_s    <= st_s;
            r_pend_e    <= st_e;
            r_pend_last <= st_last;
        end
    end

endmodule

// ===== hdl/fsts_checker.sv =====
// Port-level assertion checker for the flash stage timing scoreboard, with its bind
`include "flash_stage_timing_scoreboard_macros.svh"

module fsts_checker #(
    parameter int TIME_WIDTH = 48
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_pop,
    input logic           i_empty,
    input fsts_pkg::t_res i_res
);
    logic held, kind_ok, order_ok;

    assign held     = !i_empty && !i_pop;
    assign kind_ok  = (i_res.stage_code == fsts_pkg::STAGE_COMPUTE)
                      || (i_res.stage_code == fsts_pkg::STAGE_SLICE);
    assign order_ok = (TIME_WIDTH > fsts_pkg::OUT_TIME_W)
                      || ((i_res.stage_end >= i_res.stage_start)
                          && (i_res.latest_end >= i_res.stage_end));

    // a waiting result transaction holds until taken
    `FSTS_ASSERT_NXT(a_res_hold, held, !i_empty && $stable(i_res), "result moved while stalled")

    // only compute or slice transfer closes a command
    `FSTS_ASSERT_NOW(a_last_kind, !i_empty && i_res.last_stage, kind_ok, "last on wrong stage")

    // end never before start, running maximum covers this end
    `FSTS_ASSERT_NOW(a_time_order, !i_empty, order_ok, "stage times out of order")

endmodule

bind flash_stage_timing_scoreboard fsts_checker #(
    .TIME_WIDTH (TIME_WIDTH)
) u_fsts_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_pop   (pop),
    .i_empty (empty),
    .i_res   (o_res)
);

// ===== tb/flash_stage_timing_scoreboard_tb.sv =====
// Self-checking testbench for the flash stage timing scoreboard, with its own stage predictor
module flash_stage_timing_scoreboard_tb;

    localparam int TW            = fsts_pkg::OUT_TIME_W;
    localparam int DW            = fsts_pkg::DUR_W;
    localparam int IW            = fsts_pkg::CFG_IDX_W;
    localparam int N_CH          = 8;
    localparam int N_CP          = 8;
    localparam int N_DI          = 4;
    localparam int N_PL          = 4;
    localparam int N_IDX         = 2 ** IW;
    localparam int PHASES        = 6;
    localparam int CMDS_PER_PH   = 75;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam logic [DW-1:0] DUR_MAX = '1;

    localparam fsts_pkg::t_cmd DIRECTED [16] = '{
        '{fsts_pkg::REQ_COMPUTE, 3'd0, 3'd0, 2'd0, 2'd0},
        '{fsts_pkg::REQ_SLICE,   3'd7, 3'd7, 2'd3, 2'd3},
        '{fsts_pkg::REQ_COMPUTE, 3'd7, 3'd7, 2'd3, 2'd3},
        '{fsts_pkg::REQ_COMPUTE, 3'd7, 3'd7, 2'd3, 2'd2},
        '{fsts_pkg::REQ_COMPUTE, 3'd7, 3'd7, 2'd2, 2'd2},
        '{fsts_pkg::REQ_SLICE,   3'd7, 3'd0, 2'd0, 2'd0},
        '{fsts_pkg::REQ_SLICE,   3'd0, 3'd0, 2'd0, 2'd0},
        '{fsts_pkg::REQ_COMPUTE, 3'd0, 3'd0, 2'd0, 2'd0},
        '{fsts_pkg::REQ_SLICE,   3'd5, 3'd2, 2'd1, 2'd2},
        '{fsts_pkg::REQ_COMPUTE, 3'd2, 3'd5, 2'd2, 2'd1},
        '{fsts_pkg::REQ_COMPUTE, 3'd3, 3'd4, 2'd1, 2'd0},
        '{fsts_pkg::REQ_SLICE,   3'd3, 3'd4, 2'd1, 2'd0},
        '{fsts_pkg::REQ_COMPUTE, 3'd0, 3'd7, 2'd0, 2'd3},
        '{fsts_pkg::REQ_SLICE,   3'd7, 3'd0, 2'd3, 2'd0},
        '{fsts_pkg::REQ_COMPUTE, 3'd1, 3'd1, 2'd1, 2'd1},
        '{fsts_pkg::REQ_COMPUTE, 3'd1, 3'd1, 2'd1, 2'd1}
    };

    // first two rows on fresh resources with reset durations
    localparam int TYPED_AT [2] = '{0, 4};
    localparam fsts_pkg::t_res TYPED_STAGES [6] = '{
        '{fsts_pkg::STAGE_CMD,     48'd0,    48'd7,    48'd7,    1'b0},
        '{fsts_pkg::STAGE_VEC,     48'd7,    48'd71,   48'd71,   1'b0},
        '{fsts_pkg::STAGE_ARRAY,   48'd71,   48'd3071, 48'd3071, 1'b0},
        '{fsts_pkg::STAGE_COMPUTE, 48'd3071, 48'd3135, 48'd3135, 1'b1},
        '{fsts_pkg::STAGE_CMD,     48'd0,    48'd7,    48'd3135, 1'b0},
        '{fsts_pkg::STAGE_SLICE,   48'd7,    48'd263,  48'd3135, 1'b1}
    };

    logic           i_clk      = 1'b0;
    logic           i_rst_n    = 1'b0;
    logic           push       = 1'b0;
    logic           pop        = 1'b0;
    fsts_pkg::t_cmd i_cmd      = '0;
    logic           i_cfg_we   = 1'b0;
    logic [IW-1:0]  i_cfg_idx  = '0;
    logic [DW-1:0]  i_cfg_data = '0;
    logic           full;
    logic           empty;
    fsts_pkg::t_res o_res;

    logic [TW-1:0] chan_rdy  [N_CH];
    logic [TW-1:0] chip_rdy  [N_CH*N_CP];
    logic [TW-1:0] cu_rdy    [N_CH*N_CP*N_DI];
    logic [TW-1:0] plane_rdy [N_CH*N_CP*N_DI*N_PL];
    logic [TW-1:0] latest_end;
    logic [DW-1:0] dur_cmd, dur_vec, dur_slc, dur_arr, dur_cmp;

    fsts_pkg::t_res stage_q [$];
    int             err_cnt       = 0;
    int             cycle_cnt     = 0;
    int unsigned    send_idle_pct = 0;
    int unsigned    recv_idle_pct = 0;

    flash_stage_timing_scoreboard dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_cmd      (i_cmd),
        .empty      (empty),
        .pop        (pop),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0d] MISMATCH: %s", cycle_cnt, msg);
        err_cnt++;
    endtask

    function automatic void clear_timing();
        foreach (chan_rdy[k]) chan_rdy[k] = '0;
        foreach (chip_rdy[k]) chip_rdy[k] = '0;
        foreach (cu_rdy[k]) cu_rdy[k] = '0;
        foreach (plane_rdy[k]) plane_rdy[k] = '0;
        latest_end = '0;
        dur_cmd = fsts_pkg::RST_CMD_ADDR;
        dur_vec = fsts_pkg::RST_VEC_XFER;
        dur_slc = fsts_pkg::RST_SLC_XFER;
        dur_arr = fsts_pkg::RST_ARR_READ;
        dur_cmp = fsts_pkg::RST_COMPUTE;
    endfunction

    function automatic void apply_reg(input logic [IW-1:0] idx, input logic [DW-1:0] v);
        case (idx)
            fsts_pkg::CFG_CMD_ADDR: dur_cmd = v;
            fsts_pkg::CFG_VEC_XFER: dur_vec = v;
            fsts_pkg::CFG_SLC_XFER: dur_slc = v;
            fsts_pkg::CFG_ARR_READ: dur_arr = v;
            fsts_pkg::CFG_COMPUTE:  dur_cmp = v;
            default: ;
        endcase
    endfunction

    function automatic logic [TW-1:0] max_t(input logic [TW-1:0] a, b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [TW-1:0] sat_end(input logic [TW-1:0] s, input logic [DW-1:0] d);
        logic [TW:0] sum;
        sum = {1'b0, s} + {{(TW + 1 - DW){1'b0}}, d};
        return sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
    endfunction

    function automatic fsts_pkg::t_res stage_rec(input logic [2:0] code,
                                                 input logic [TW-1:0] s, e,
                                                 input logic last);
        fsts_pkg::t_res r;
        if (e > latest_end) latest_end = e;
        r.stage_code  = code;
        r.stage_start = s;
        r.stage_end   = e;
        r.latest_end  = latest_end;
        r.last_stage  = last;
        return r;
    endfunction

    function automatic void schedule_stages(input fsts_pkg::t_cmd c,
                                            output fsts_pkg::t_res res [$]);
        int ch, cp, di, pl;
        logic [TW-1:0] s, e;
        ch = int'(c.channel_idx) % N_CH;
        cp = ch * N_CP + int'(c.chip_idx) % N_CP;
        di = cp * N_DI + int'(c.die_idx) % N_DI;
        pl = di * N_PL + int'(c.plane_idx) % N_PL;
        res = {};
        s = max_t(chan_rdy[ch], chip_rdy[cp]);
        e = sat_end(s, dur_cmd);
        chan_rdy[ch] = e;
        chip_rdy[cp] = e;
        res.push_back(stage_rec(fsts_pkg::STAGE_CMD, s, e, 1'b0));
        if (c.req_type == fsts_pkg::REQ_SLICE) begin
            s = max_t(chan_rdy[ch], chip_rdy[cp]);
            e = sat_end(s, dur_slc);
            chan_rdy[ch] = e;
            chip_rdy[cp] = e;
            res.push_back(stage_rec(fsts_pkg::STAGE_SLICE, s, e, 1'b1));
            return;
        end
        s = max_t(chan_rdy[ch], chip_rdy[cp]);
        e = sat_end(s, dur_vec);
        chan_rdy[ch] = e;
        chip_rdy[cp] = e;
        res.push_back(stage_rec(fsts_pkg::STAGE_VEC, s, e, 1'b0));
        s = max_t(chip_rdy[cp], plane_rdy[pl]);
        e = sat_end(s, dur_arr);
        chip_rdy[cp]  = e;
        plane_rdy[pl] = e;
        res.push_back(stage_rec(fsts_pkg::STAGE_ARRAY, s, e, 1'b0));
        s = max_t(e, cu_rdy[di]);
        e = sat_end(s, dur_cmp);
        cu_rdy[di]    = e;
        chip_rdy[cp]  = e;
        plane_rdy[pl] = e;
        res.push_back(stage_rec(fsts_pkg::STAGE_COMPUTE, s, e, 1'b1));
    endfunction

    function automatic fsts_pkg::t_cmd rand_cmd();
        fsts_pkg::t_cmd c;
        c.req_type    = 1'($urandom_range(1));
        c.channel_idx = 3'($urandom_range(7));
        c.chip_idx    = 3'($urandom_range(7));
        c.die_idx     = 2'($urandom_range(3));
        c.plane_idx   = 2'($urandom_range(3));
        // crowd most commands onto a few chips so resources collide
        if ($urandom_range(99) < 60) begin
            c.channel_idx = 3'($urandom_range(1));
            c.chip_idx    = 3'($urandom_range(1));
        end
        return c;
    endfunction

    task automatic send_cmd(input fsts_pkg::t_cmd c, input int typed_at);
        fsts_pkg::t_res pred [$];
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push  <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        schedule_stages(c, pred);
        foreach (pred[k]) begin
            stage_q.push_back((typed_at < 0) ? pred[k] : TYPED_STAGES[typed_at + k]);
        end
    endtask

    task automatic drain_stages();
        push <= 1'b0;
        do @(posedge i_clk); while (stage_q.size() != 0);
    endtask

    task automatic write_durations(input logic [DW-1:0] d_cmd, d_vec, d_slc, d_arr, d_cmp,
                                   input bit poke_unused);
        logic [DW-1:0] vals [N_IDX];
        int n;
        foreach (vals[k]) vals[k] = DW'($urandom);
        vals[fsts_pkg::CFG_CMD_ADDR] = d_cmd;
        vals[fsts_pkg::CFG_VEC_XFER] = d_vec;
        vals[fsts_pkg::CFG_SLC_XFER] = d_slc;
        vals[fsts_pkg::CFG_ARR_READ] = d_arr;
        vals[fsts_pkg::CFG_COMPUTE]  = d_cmp;
        n = poke_unused ? N_IDX : int'(fsts_pkg::CFG_COMPUTE) + 1;
        for (int k = 0; k < n; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= IW'(k);
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            apply_reg(IW'(k), vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic check_stage(input fsts_pkg::t_res got);
        fsts_pkg::t_res want;
        logic [TW-1:0] g [5];
        logic [TW-1:0] w [5];
        string names [5];
        if (stage_q.size() == 0) begin
            report_mismatch($sformatf("transaction with nothing expected: stage %0d start %0d",
                                      got.stage_code, got.stage_start));
            return;
        end
        want = stage_q.pop_front();
        names = '{"stage_code", "stage_start", "stage_end", "latest_end", "last_stage"};
        g = '{TW'(got.stage_code), got.stage_start, got.stage_end, got.latest_end,
              TW'(got.last_stage)};
        w = '{TW'(want.stage_code), want.stage_start, want.stage_end, want.latest_end,
              TW'(want.last_stage)};
        foreach (names[k]) begin
            if (g[k] !== w[k]) begin
                report_mismatch($sformatf("%s got %0d want %0d (stage %0d)",
                                          names[k], g[k], w[k], want.stage_code));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) check_stage(o_res);
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        clear_timing();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[r]) send_cmd(DIRECTED[r], (r < 2) ? TYPED_AT[r] : -1);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_stages();
            case (ph)
                0: write_durations('0, '0, '0, '0, '0, 1'b1);
                1: write_durations(DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, 1'b0);
                2: write_durations(24'd1, 24'd1, 24'd1, 24'd1, 24'd1, 1'b0);
                3: write_durations(DW'($urandom), DW'($urandom), DW'($urandom),
                                   DW'($urandom), DW'($urandom), 1'b1);
                4: write_durations(DW'($urandom_range(16)), DW'($urandom_range(16)),
                                   DW'($urandom_range(16)), DW'($urandom_range(16)),
                                   DW'($urandom_range(16)), 1'b0);
                default: write_durations(fsts_pkg::RST_CMD_ADDR, fsts_pkg::RST_VEC_XFER,
                                         fsts_pkg::RST_SLC_XFER, fsts_pkg::RST_ARR_READ,
                                         fsts_pkg::RST_COMPUTE, 1'b0);
            endcase
            send_idle_pct = (ph < 2) ? 7 : ((ph < 4) ? 62 : 0);
            recv_idle_pct = (ph < 2) ? 62 : ((ph < 4) ? 7 : 0);
            for (int n = 0; n < CMDS_PER_PH; n++) begin
                if (ph == 3 && n == CMDS_PER_PH / 2) drain_stages();
                send_cmd(rand_cmd(), -1);
            end
        end

        drain_stages();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== flash_stage_timing_scoreboard.f =====
+incdir+hdl
hdl/fsts_pkg.sv
hdl/fsts_fifo.sv
hdl/fsts_front.sv
hdl/fsts_back.sv
hdl/flash_stage_timing_scoreboard.sv
hdl/fsts_checker.sv
tb/flash_stage_timing_scoreboard_tb.sv
